### rtl/pip_pkg.sv
// shared constants and controller/datapath handshake types for the polygon test
package pip_pkg;

	localparam int MAX_VERTICES_DEF = 64;
	localparam int COORD_WIDTH_DEF  = 24;
	localparam int COUNT_W          = 7;
	localparam int INDEX_W          = 6;

	localparam logic FUNC_WRITE = 1'b0;
	localparam logic FUNC_TEST  = 1'b1;

	typedef struct packed {
		logic               wr_en;
		logic               start;
		logic               rd_en;
		logic [COUNT_W-1:0] rd_idx;
		logic               rd_first;
		logic               rd_near;
		logic               load_res;
	} pip_cmd_t;

	typedef struct packed {
		logic pipe_busy;
		logic out_busy;
	} pip_sts_t;

endpackage

### rtl/pip_if.sv
// stream interfaces for vertex/test items and inside results
interface pip_in_if import pip_pkg::*; #(
	parameter int COORD_WIDTH = COORD_WIDTH_DEF
) ();
	logic                          valid;
	logic                          ready;
	logic                          func;
	logic [INDEX_W-1:0]            vertex_index;
	logic signed [COORD_WIDTH-1:0] coord_x;
	logic signed [COORD_WIDTH-1:0] coord_y;

	modport source (output valid, func, vertex_index, coord_x, coord_y, input ready);
	modport sink (input valid, func, vertex_index, coord_x, coord_y, output ready);
endinterface

interface pip_out_if ();
	logic valid;
	logic ready;
	logic inside_res;

	modport source (output valid, inside_res, input ready);
	modport sink (input valid, inside_res, output ready);
endinterface

### rtl/point_in_polygon_crossings.sv
// top level: even-odd crossings point-in-polygon test over a loaded vertex table
//
//  channel   dir  handshake          payload
//  item      in   valid/ready        func, vertex_index, coord_x, coord_y
//  result    out  valid/ready        inside_res
//  cfg       in   cfg_we             cfg_wdata (vertex_count)
//
//  a vertex write gives no result
//  a test reads one vertex per cycle from the single table read port, with the
//  vertex count capped at the table depth, and reads no vertex at all with
//  fewer than two vertices
//  items are refused while a test runs; a waiting result stalls only the next test
//  reset clears the count and control state; the table is undefined until written
module point_in_polygon_crossings import pip_pkg::*; #(
	parameter int MAX_VERTICES = MAX_VERTICES_DEF,
	parameter int COORD_WIDTH  = COORD_WIDTH_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	pip_in_if.sink             item,
	pip_out_if.source          result,
	input  logic               cfg_we,
	input  logic [COUNT_W-1:0] cfg_wdata
);

	pip_cmd_t cmd;
	pip_sts_t sts;
	logic     ready;

	assign item.ready = ready;

	pip_ctrl #(
		.MAX_VERTICES (MAX_VERTICES)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (item.valid),
		.in_func   (item.func),
		.in_ready  (ready),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.sts       (sts),
		.cmd       (cmd)
	);

	pip_datapath #(
		.MAX_VERTICES (MAX_VERTICES),
		.COORD_WIDTH  (COORD_WIDTH)
	) u_datapath (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.sts          (sts),
		.vertex_index (item.vertex_index),
		.coord_x      (item.coord_x),
		.coord_y      (item.coord_y),
		.result       (result)
	);

	a_no_accept_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		(sts.pipe_busy || cmd.rd_en) |-> !ready)
		else $error("item taken while edge walk in flight");

	a_load_when_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load_res |-> (!sts.out_busy && !sts.pipe_busy))
		else $error("result loaded over pending result or busy pipeline");

	a_test_blocks_input: assert property (@(posedge clk) disable iff (!arst_n)
		(item.valid && ready && item.func == FUNC_TEST) |=> !ready)
		else $error("input still open after test transfer");

endmodule

### rtl/pip_ctrl.sv
// controller: item handshake, vertex count register and edge walk sequencing
module pip_ctrl import pip_pkg::*; #(
	parameter int MAX_VERTICES = MAX_VERTICES_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	input  logic               in_func,
	output logic               in_ready,
	input  logic               cfg_we,
	input  logic [COUNT_W-1:0] cfg_wdata,
	input  pip_sts_t           sts,
	output pip_cmd_t           cmd
);

	localparam logic [1:0] ST_IDLE  = 2'd0;
	localparam logic [1:0] ST_RUN   = 2'd1;
	localparam logic [1:0] ST_DRAIN = 2'd2;

	logic [1:0]         state_q;
	logic [1:0]         state_d;
	logic [COUNT_W-1:0] count_q;
	logic [COUNT_W-1:0] n_vtx;
	logic [COUNT_W-1:0] k_q;
	logic [COUNT_W-1:0] k_d;
	logic               accept;

	// saturate to table depth
	assign n_vtx = (32'(count_q) > MAX_VERTICES) ? COUNT_W'(MAX_VERTICES) : count_q;

	assign in_ready = (state_q == ST_IDLE);
	assign accept   = in_valid && in_ready;

	always_comb begin
		state_d      = state_q;
		k_d          = k_q;
		cmd          = '0;
		cmd.wr_en    = accept && (in_func == FUNC_WRITE);
		cmd.start    = accept && (in_func == FUNC_TEST);
		cmd.rd_idx   = k_q;
		cmd.rd_first = (k_q == '0);
		cmd.rd_near  = ({1'b0, k_q} + (COUNT_W+1)'(2)) < {1'b0, n_vtx};
		unique case (state_q)
			ST_IDLE: begin
				k_d = '0;
				if (cmd.start) begin
					state_d = (n_vtx < COUNT_W'(2)) ? ST_DRAIN : ST_RUN;
				end
			end
			ST_RUN: begin
				cmd.rd_en = 1'b1;
				k_d       = k_q + COUNT_W'(1);
				if (k_q == n_vtx - COUNT_W'(1)) begin
					state_d = ST_DRAIN;
				end
			end
			ST_DRAIN: begin
				if (!sts.pipe_busy && !sts.out_busy) begin
					cmd.load_res = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			k_q     <= '0;
			count_q <= '0;
		end else begin
			state_q <= state_d;
			k_q     <= k_d;
			if (cfg_we) begin
				count_q <= cfg_wdata;
			end
		end
	end

endmodule

### rtl/pip_datapath.sv
// datapath: vertex memory, edge straddle pipeline, cross product compare, result register
module pip_datapath import pip_pkg::*; #(
	parameter int MAX_VERTICES = MAX_VERTICES_DEF,
	parameter int COORD_WIDTH  = COORD_WIDTH_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  pip_cmd_t                      cmd,
	output pip_sts_t                      sts,
	input  logic [INDEX_W-1:0]            vertex_index,
	input  logic signed [COORD_WIDTH-1:0] coord_x,
	input  logic signed [COORD_WIDTH-1:0] coord_y,
	pip_out_if.source                     result
);

	localparam int W      = COORD_WIDTH;
	localparam int DW     = COORD_WIDTH + 1;
	localparam int PW     = 2 * COORD_WIDTH + 2;
	localparam int ADDR_W = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;

	logic signed [W-1:0] mem_x [MAX_VERTICES];
	logic signed [W-1:0] mem_y [MAX_VERTICES];

	logic signed [W-1:0] tx_q, ty_q;
	logic signed [W-1:0] prev_x_q, prev_y_q;
	logic signed [W-1:0] first_x_q, first_y_q;
	logic                f_prev_q;
	logic                skip_q;
	logic                inside_q;
	logic                out_valid_q;
	logic                out_inside_q;

	// stage 1: memory read
	logic                v_s1, first_s1, near_s1;
	logic signed [W-1:0] x_s1, y_s1;
	// stage 2: differences
	logic                 v_s2, edge_s2, f1_s2;
	logic signed [DW-1:0] dy1_s2, dx01_s2, dx1_s2, dy01_s2;
	// stage 3: products
	logic                 v_s3, edge_s3, f1_s3;
	logic signed [PW-1:0] lhs_s3, rhs_s3;

	logic is_head, f1, straddle, loop_closed;

	// vertex writes, slots past the table dropped
	always_ff @(posedge clk) begin
		if (cmd.wr_en && (32'(vertex_index) < MAX_VERTICES)) begin
			mem_x[ADDR_W'(vertex_index)] <= coord_x;
			mem_y[ADDR_W'(vertex_index)] <= coord_y;
		end
		x_s1 <= mem_x[ADDR_W'(cmd.rd_idx)];
		y_s1 <= mem_y[ADDR_W'(cmd.rd_idx)];
	end

	assign is_head     = first_s1 || skip_q;
	assign f1          = (y_s1 >= ty_q);
	assign straddle    = !is_head && (f_prev_q != f1);
	assign loop_closed = !is_head && near_s1 && (x_s1 == first_x_q) && (y_s1 == first_y_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1         <= 1'b0;
			v_s2         <= 1'b0;
			v_s3         <= 1'b0;
			edge_s2      <= 1'b0;
			edge_s3      <= 1'b0;
			skip_q       <= 1'b0;
			inside_q     <= 1'b0;
			out_valid_q  <= 1'b0;
		end else begin
			v_s1    <= cmd.rd_en;
			v_s2    <= v_s1;
			v_s3    <= v_s2;
			edge_s2 <= v_s1 && straddle;
			edge_s3 <= v_s2 && edge_s2;
			if (cmd.start) begin
				skip_q <= 1'b0;
			end else if (v_s1) begin
				skip_q <= loop_closed;
			end
			if (cmd.start) begin
				inside_q <= 1'b0;
			end else if (v_s3 && edge_s3 && ((lhs_s3 >= rhs_s3) == f1_s3)) begin
				inside_q <= !inside_q;
			end
			if (cmd.load_res) begin
				out_valid_q <= 1'b1;
			end else if (result.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		first_s1 <= cmd.rd_first;
		near_s1  <= cmd.rd_near;
		if (cmd.start) begin
			tx_q <= coord_x;
			ty_q <= coord_y;
		end
		if (v_s1) begin
			prev_x_q <= x_s1;
			prev_y_q <= y_s1;
			f_prev_q <= f1;
			if (is_head) begin
				first_x_q <= x_s1;
				first_y_q <= y_s1;
			end
		end
		f1_s2   <= f1;
		dy1_s2  <= $signed({y_s1[W-1], y_s1}) - $signed({ty_q[W-1], ty_q});
		dx01_s2 <= $signed({prev_x_q[W-1], prev_x_q}) - $signed({x_s1[W-1], x_s1});
		dx1_s2  <= $signed({x_s1[W-1], x_s1}) - $signed({tx_q[W-1], tx_q});
		dy01_s2 <= $signed({prev_y_q[W-1], prev_y_q}) - $signed({y_s1[W-1], y_s1});
		f1_s3   <= f1_s2;
		lhs_s3  <= dy1_s2 * dx01_s2;
		rhs_s3  <= dx1_s2 * dy01_s2;
		if (cmd.load_res) begin
			out_inside_q <= inside_q;
		end
	end

	assign sts.pipe_busy = v_s1 || v_s2 || v_s3;
	assign sts.out_busy  = out_valid_q;

	assign result.valid      = out_valid_q;
	assign result.inside_res = out_inside_q;

endmodule
